>>> rtl/smf_pkg.sv
package smf_pkg;

  typedef enum logic [4:0] {
    PH_MTHD, PH_HLEN, PH_FMT, PH_NTRK, PH_DIV, PH_HSKIP, PH_MTRK, PH_TLEN,
    PH_DELTA, PH_STATUS, PH_D1, PH_D2, PH_SXLEN, PH_SXBODY, PH_MTYPE,
    PH_MLEN, PH_MBODY, PH_TSKIP, PH_DONE, PH_ERR
  } phase_e;

  typedef enum logic [1:0] {
    FN_DATA = 2'd0, FN_START = 2'd1, FN_EOF = 2'd2, FN_NONE = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    EV_NONE = 4'd0, EV_CHAN = 4'd1, EV_META = 4'd2, EV_SYSEX = 4'd3,
    EV_SYS = 4'd4, EV_RT = 4'd5, EV_TEND = 4'd6, EV_DONE = 4'd7,
    EV_ERR = 4'd8, EV_HDR = 4'd9
  } event_e;

  typedef enum logic [2:0] {
    ER_NONE = 3'd0, ER_MTHD = 3'd1, ER_HSHORT = 3'd2, ER_FMT = 3'd3,
    ER_MTRK = 3'd4, ER_NORS = 3'd5, ER_VLEN = 3'd6, ER_TRUNC = 3'd7
  } err_e;

  // One result word, the fields in port order.
  typedef struct packed {
    logic [31:0] length_excess;
    logic [2:0]  error_code;
    logic [15:0] track_index;
    logic        meta_last;
    logic [7:0]  meta_value;
    logic [7:0]  meta_kind;
    logic [31:0] delta_time;
    logic [7:0]  second_data;
    logic [7:0]  first_data;
    logic [7:0]  status_byte;
    logic [3:0]  event_kind;
  } result_t;

  // Input word as registered at the front.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } item_t;

  function automatic logic [7:0] tag_byte(input logic trk, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h4d;
      2'd1: r = 8'h54;
      2'd2: r = trk ? 8'h72 : 8'h68;
      default: r = trk ? 8'h6b : 8'h64;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/smf_core.sv
module smf_core #(
  parameter int unsigned VarlenMaxBytes = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  smf_pkg::item_t  item_i,
  output smf_pkg::result_t res_o
);
  import smf_pkg::*;

  phase_e      ph_q, ph_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [31:0] hlen_q, hlen_d;
  logic [15:0] fmt_q, fmt_d, ntrk_q, ntrk_d, tcnt_q, tcnt_d;
  logic [31:0] tlen_q, tlen_d, seen_q, seen_d, acc_q, acc_d, skip_q, skip_d;
  logic [8:0]  rs_q, rs_d;
  logic [7:0]  cur_q, cur_d, held_q, held_d, mk_q, mk_d;
  logic [3:0]  vcnt_q, vcnt_d;
  logic [2:0]  err_q, err_d;

  logic [7:0]  b;
  logic [31:0] vl_in, vl_val, rem;
  logic [3:0]  vl_cnt;
  logic        vl_more, vl_long, last_trk, two, is_text, fmt_bad;
  logic [31:0] skip_dec;
  result_t     r;

  assign b        = item_i.data_byte;
  assign vl_in    = (ph_q == PH_DELTA) ? acc_q : skip_q;
  assign vl_val   = {vl_in[24:0], b[6:0]};
  assign vl_cnt   = vcnt_q + 4'd1;
  assign vl_more  = b[7];
  assign vl_long  = vl_more && (vl_cnt >= 4'(VarlenMaxBytes));
  assign last_trk = (fmt_q == 16'd0) || ({1'b0, tcnt_q} + 17'd1 >= {1'b0, ntrk_q});
  assign two      = (cur_q[7:4] != 4'hc) && (cur_q[7:4] != 4'hd);
  assign is_text  = (mk_q >= 8'd1) && (mk_q <= 8'd15);
  // Bytes still declared for the track once the current byte is counted.
  assign rem      = tlen_q - seen_q - 32'd1;
  assign skip_dec = skip_q - 32'd1;
  assign fmt_bad  = fmt_q > 16'd1;

  always_comb begin
    logic [31:0] seen_n;
    logic        tend, nxt_trk, nxt_evt, hfin;
    ph_d = ph_q; fbc_d = fbc_q; hlen_d = hlen_q; fmt_d = fmt_q; ntrk_d = ntrk_q;
    tcnt_d = tcnt_q; tlen_d = tlen_q; seen_d = seen_q; rs_d = rs_q; cur_d = cur_q;
    held_d = held_q; acc_d = acc_q; vcnt_d = vcnt_q; skip_d = skip_q; mk_d = mk_q;
    err_d = err_q;
    r = '0;
    tend = 1'b0; nxt_trk = 1'b0; nxt_evt = 1'b0; hfin = 1'b0;
    seen_n = seen_q + 32'd1;
    case (func_e'(item_i.func))
      FN_START: begin
        ph_d = PH_MTHD; fbc_d = '0; hlen_d = '0; fmt_d = '0; ntrk_d = '0;
        tcnt_d = '0; tlen_d = '0; seen_d = '0; rs_d = '0; cur_d = '0;
        held_d = '0; acc_d = '0; vcnt_d = '0; skip_d = '0; mk_d = '0;
        err_d = '0;
      end
      FN_EOF: begin
        case (ph_q)
          PH_MTHD: begin err_d = ER_MTHD; ph_d = PH_ERR; r.event_kind = EV_ERR; end
          PH_MTRK: begin err_d = ER_MTRK; ph_d = PH_ERR; r.event_kind = EV_ERR; end
          PH_TSKIP: begin
            if (last_trk) begin
              ph_d = PH_DONE; r.event_kind = EV_DONE;
            end else begin
              err_d = ER_MTRK; ph_d = PH_ERR; r.event_kind = EV_ERR;
            end
          end
          PH_DONE: r.event_kind = EV_DONE;
          PH_ERR: ;
          default: begin err_d = ER_TRUNC; ph_d = PH_ERR; r.event_kind = EV_ERR; end
        endcase
      end
      FN_DATA: begin
        if (ph_q inside {[PH_DELTA:PH_MBODY]}) seen_d = seen_n;
        case (ph_q)
          PH_MTHD, PH_MTRK: begin
            if (b != tag_byte(ph_q == PH_MTRK, fbc_q[1:0])) begin
              err_d = (ph_q == PH_MTHD) ? ER_MTHD : ER_MTRK;
              ph_d = PH_ERR; r.event_kind = EV_ERR;
            end else if (fbc_q == 4'd3) begin
              fbc_d = '0;
              if (ph_q == PH_MTHD) begin hlen_d = '0; ph_d = PH_HLEN; end
              else begin tlen_d = '0; ph_d = PH_TLEN; end
            end else fbc_d = fbc_q + 4'd1;
          end
          PH_HLEN: begin
            hlen_d = {hlen_q[23:0], b};
            fbc_d = fbc_q + 4'd1;
            if (fbc_q == 4'd3) begin
              fbc_d = '0;
              if (hlen_d < 32'd6 || hlen_d[31]) begin
                err_d = ER_HSHORT; ph_d = PH_ERR; r.event_kind = EV_ERR;
              end else ph_d = PH_FMT;
            end
          end
          PH_FMT: begin
            fmt_d = {fmt_q[7:0], b}; fbc_d = fbc_q + 4'd1;
            if (fbc_q == 4'd1) begin fbc_d = '0; ph_d = PH_NTRK; end
          end
          PH_NTRK: begin
            ntrk_d = {ntrk_q[7:0], b}; fbc_d = fbc_q + 4'd1;
            if (fbc_q == 4'd1) begin fbc_d = '0; ph_d = PH_DIV; end
          end
          PH_DIV: begin
            fbc_d = fbc_q + 4'd1;
            if (fbc_q == 4'd1) begin
              fbc_d = '0;
              if (hlen_q > 32'd6) begin skip_d = hlen_q - 32'd6; ph_d = PH_HSKIP; end
              else hfin = 1'b1;
            end
          end
          PH_HSKIP: begin
            skip_d = skip_dec;
            if (skip_dec == '0) hfin = 1'b1;
          end
          PH_TLEN: begin
            tlen_d = {tlen_q[23:0], b}; fbc_d = fbc_q + 4'd1;
            if (fbc_q == 4'd3) begin
              fbc_d = '0; seen_d = '0; rs_d = '0; nxt_evt = 1'b1;
            end
          end
          PH_DELTA: begin
            acc_d = vl_val; vcnt_d = vl_more ? vl_cnt : 4'd0;
            if (vl_long) begin err_d = ER_VLEN; ph_d = PH_ERR; r.event_kind = EV_ERR; end
            else if (!vl_more) ph_d = PH_STATUS;
          end
          PH_STATUS: begin
            if (!b[7]) begin
              if (!rs_q[8]) begin
                err_d = ER_NORS; ph_d = PH_ERR; r.event_kind = EV_ERR;
              end else begin
                cur_d = rs_q[7:0];
                if ((rs_q[7:4] != 4'hc) && (rs_q[7:4] != 4'hd)) begin
                  held_d = b; ph_d = PH_D2;
                end else begin
                  r.event_kind = EV_CHAN; r.status_byte = rs_q[7:0];
                  r.first_data = b; nxt_evt = 1'b1;
                end
              end
            end else if (b[7:4] != 4'hf) begin
              cur_d = b; rs_d = {1'b1, b}; ph_d = PH_D1;
            end else if (b == 8'hf0) begin
              rs_d = '0; skip_d = '0; ph_d = PH_SXLEN;
            end else if (b == 8'hff) begin
              rs_d = '0; ph_d = PH_MTYPE;
            end else begin
              r.event_kind = (b <= 8'hf6) ? EV_SYS : EV_RT;
              r.status_byte = b; nxt_evt = 1'b1;
            end
          end
          PH_D1: begin
            if (two) begin held_d = b; ph_d = PH_D2; end
            else begin
              r.event_kind = EV_CHAN; r.status_byte = cur_q; r.first_data = b;
              nxt_evt = 1'b1;
            end
          end
          PH_D2: begin
            r.event_kind = EV_CHAN; r.status_byte = cur_q; r.first_data = held_q;
            r.second_data = b; nxt_evt = 1'b1;
          end
          PH_SXLEN: begin
            skip_d = vl_val; vcnt_d = vl_more ? vl_cnt : 4'd0;
            if (vl_long) begin err_d = ER_VLEN; ph_d = PH_ERR; r.event_kind = EV_ERR; end
            else if (!vl_more) begin
              if (vl_val == '0) begin
                r.event_kind = EV_SYSEX; r.status_byte = 8'hf0; nxt_evt = 1'b1;
              end else ph_d = PH_SXBODY;
            end
          end
          PH_SXBODY: begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              r.event_kind = EV_SYSEX; r.status_byte = 8'hf0; nxt_evt = 1'b1;
            end
          end
          PH_MTYPE: begin mk_d = b; skip_d = '0; ph_d = PH_MLEN; end
          PH_MLEN: begin
            skip_d = vl_val; vcnt_d = vl_more ? vl_cnt : 4'd0;
            if (vl_long) begin err_d = ER_VLEN; ph_d = PH_ERR; r.event_kind = EV_ERR; end
            else if (!vl_more) begin
              if (vl_val != '0) ph_d = PH_MBODY;
              else if (mk_q == 8'h2f) tend = 1'b1;
              else begin
                if (is_text) begin
                  r.event_kind = EV_META; r.status_byte = 8'hff;
                  r.meta_kind = mk_q; r.meta_last = 1'b1;
                end
                nxt_evt = 1'b1;
              end
            end
          end
          PH_MBODY: begin
            skip_d = skip_dec;
            if (is_text) begin
              r.event_kind = EV_META; r.status_byte = 8'hff; r.meta_kind = mk_q;
              r.meta_value = b; r.meta_last = (skip_dec == '0);
            end
            if (skip_dec == '0) begin
              if (mk_q == 8'h2f) tend = 1'b1;
              else nxt_evt = 1'b1;
            end
          end
          PH_TSKIP: begin
            skip_d = skip_dec;
            if (skip_dec == '0) nxt_trk = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (hfin) begin
      if (fmt_bad) begin
        err_d = ER_FMT; ph_d = PH_ERR; r.event_kind = EV_ERR;
      end else begin
        r.event_kind = EV_HDR; tcnt_d = '0; fbc_d = '0;
        ph_d = (fmt_q == 16'd1 && ntrk_q == 16'd0) ? PH_DONE : PH_MTRK;
      end
    end
    if (tend) begin
      // Track length check uses the count including this byte.
      r.event_kind = EV_TEND; r.status_byte = 8'hff; r.meta_kind = 8'h2f;
      r.length_excess = seen_n - tlen_q;
      if (rem != '0 && !rem[31]) begin
        skip_d = rem; ph_d = PH_TSKIP;
      end else nxt_trk = 1'b1;
    end
    if (nxt_evt) begin acc_d = '0; vcnt_d = '0; ph_d = PH_DELTA; end
    if (nxt_trk) begin
      tcnt_d = tcnt_q + 16'd1; fbc_d = '0;
      ph_d = last_trk ? PH_DONE : PH_MTRK;
    end
    r.error_code = err_d;
    // Results carry the counter before this byte; idle results show it after.
    r.track_index = (r.event_kind == EV_NONE) ? tcnt_d : tcnt_q;
    if (r.event_kind inside {[EV_CHAN:EV_TEND]}) r.delta_time = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MTHD; fbc_q <= '0; hlen_q <= '0; fmt_q <= '0; ntrk_q <= '0;
      tcnt_q <= '0; tlen_q <= '0; seen_q <= '0; rs_q <= '0; cur_q <= '0;
      held_q <= '0; acc_q <= '0; vcnt_q <= '0; skip_q <= '0; mk_q <= '0;
      err_q <= '0;
    end else if (step_i) begin
      ph_q <= ph_d; fbc_q <= fbc_d; hlen_q <= hlen_d; fmt_q <= fmt_d;
      ntrk_q <= ntrk_d; tcnt_q <= tcnt_d; tlen_q <= tlen_d; seen_q <= seen_d;
      rs_q <= rs_d; cur_q <= cur_d; held_q <= held_d; acc_q <= acc_d;
      vcnt_q <= vcnt_d; skip_q <= skip_d; mk_q <= mk_d; err_q <= err_d;
    end
  end

  assign res_o = r;

  property p_err_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      (ph_q == PH_ERR && step_i && item_i.func != FN_START) |=> (ph_q == PH_ERR);
  endproperty
  a_err_holds: assert property (p_err_holds) else $error("error phase left");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (ph_q == PH_ERR) |-> (err_q != ER_NONE)) else $error("error phase without code");

  a_vcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
      vcnt_q <= 4'(VarlenMaxBytes)) else $error("varlen count overrun");
endmodule

>>> rtl/midi_file_track_parser_top.sv
// Channel   | Dir | Signals                        | Word
// s_axis    | in  | s_axis_tvalid/tready/tdata/tuser | data_byte in tdata, func in tuser
// m_axis    | out | m_axis_tvalid/tready/tdata     | one packed result per input word
//
// Every accepted input word yields exactly one result word, one per cycle
// while the output is not stalled. An input register feeds the single-pass
// parser logic, whose result lands in an output register; the parser state
// advances when the input register is consumed. A word waits in the input
// register until the output register can take its result. rst_ni clears all
// parser state asynchronously. A stalled output holds the input register
// full, and the input side stalls only then.
module midi_file_track_parser_top #(
  parameter int unsigned VARLEN_MAX_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [127:0] m_axis_tdata   // event_kind, status_byte, first_data,
                                      // second_data, delta_time, meta_kind,
                                      // meta_value, meta_last, track_index,
                                      // error_code, length_excess
);
  import smf_pkg::*;

  logic    in_v_q, out_v_q, step;
  item_t   in_q;
  result_t res, out_q;

  // The input stage moves forward when the output register is free or draining.
  assign step          = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      if (step) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= '{func: s_axis_tuser, data_byte: s_axis_tdata};
    if (step) out_q <= res;
  end

  smf_core #(.VarlenMaxBytes(VARLEN_MAX_BYTES)) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_q),
    .res_o (res)
  );

  assign m_axis_tvalid = out_v_q;
  // The packed result is exactly 128 bits wide.
  assign m_axis_tdata  = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_v_q && !m_axis_tready) |=> $stable(out_q)) else $error("result changed");
  a_step_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
      step |-> in_v_q) else $error("step without word");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
      step |=> out_v_q) else $error("result lost");
endmodule
